// File: rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared constants, codes and payload types of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	// Sizing
	localparam int FRAG_SIZE   = 512;
	localparam int MAX_VOICES  = 16;
	localparam int SOUND_COUNT = 8;
	localparam int MAX_FRAGS   = 32;

	localparam int SND_W  = 3;                        // sound_id field width
	localparam int LEN_W  = 6;                        // length register width
	localparam int POS_W  = 6;                        // voice position width
	localparam int OFF_W  = $clog2(FRAG_SIZE);        // sample within fragment
	localparam int FRAG_W = $clog2(MAX_FRAGS);        // fragment within sound
	localparam int ADDR_W = SND_W + FRAG_W + OFF_W;   // sample memory address
	localparam int VIDX_W = $clog2(MAX_VOICES);       // voice table index
	localparam int CNT_W  = $clog2(MAX_VOICES + 1);   // voice count
	localparam int ACC_W  = 8 + VIDX_W + 1;           // signed mix accumulator
	localparam int CFG_W  = 3;                        // register index width

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Request codes
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// Request status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  request;
		logic [2:0]  sound_id;
		logic [13:0] byte_addr;
		logic [7:0]  raw_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] mixed_sample;
		logic [1:0] request_status;
		logic       fragment_start;
		logic [4:0] voices_active;
	} result_t;

	// One voice table entry
	typedef struct packed {
		logic [SND_W-1:0] sound;
		logic [POS_W-1:0] pos;
	} voice_t;

	// Voice table write request
	typedef struct packed {
		logic              en;
		logic [VIDX_W-1:0] idx;
		voice_t            data;
	} vt_wr_t;

	// Saturate a length register to the sound memory size
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		if (len > LEN_W'(MAX_FRAGS))
			return LEN_W'(MAX_FRAGS);
		return len;
	endfunction

endpackage

// File: rtl/mvsm_sample_ram.sv
// ----------------------------------------------------------------------------
// mvsm_sample_ram
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvsm_sample_ram
	import mvsm_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata_s1
);

	logic [7:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata_s1 <= mem[raddr];
	end

endmodule

// File: rtl/mvsm_voice_table.sv
// ----------------------------------------------------------------------------
// mvsm_voice_table
// Table of active voices: sound and fragment position per slot, one read
// index and one write port.
// ----------------------------------------------------------------------------
module mvsm_voice_table
	import mvsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  vt_wr_t            wr,
	input  logic [VIDX_W-1:0] rd_idx,
	output voice_t            rd_data
);

	voice_t voice_q [MAX_VOICES];

	// Update one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VOICES; i++)
				voice_q[i] <= '0;
		end else if (wr.en) begin
			voice_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = voice_q[rd_idx];

endmodule

// File: rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sixteen-voice PCM mixer with a saturating 8-bit output stage.
// ----------------------------------------------------------------------------
// A load transaction (cmd = 0) writes one sample byte in the accept cycle and
// leaves busy low. A tick transaction (cmd = 1) raises busy and produces one
// result, shown for a single cycle with result_valid; the receiver cannot
// stall it, so capture it on that edge. A tick does one sample-memory read
// per active voice through the shared read port and accumulator; on the
// first sample of a fragment a voice-table compaction pass over the voices
// (one slot per cycle) runs in front of that. Length registers may be
// written at any idle time and take effect on the next fragment start.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer
	import mvsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             result_valid,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_addr,
	input  logic [LEN_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MIX,
		S_WAIT,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [LEN_W-1:0]     len_q [SOUND_COUNT];
	logic [CNT_W-1:0]     cnt_q;
	logic [OFF_W-1:0]     sif_q;
	logic [CNT_W-1:0]     rd_q;
	logic [CNT_W-1:0]     wr_q;
	logic                 fstart_q;
	logic [1:0]           status_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                 vld_s1;
	logic                 zero_s1;
	logic [7:0]           rdata_s1;

	vt_wr_t               vt_wr;
	voice_t               vt_rd;
	logic                 accept;
	logic                 tick_acc;
	logic                 frag_first;
	logic                 start_ok;
	logic                 keep;
	logic                 last_sample;
	logic                 mix_go;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]    ram_raddr;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign tick_acc    = accept && (item.cmd == CMD_TICK);
	assign frag_first  = (sif_q == '0);
	assign start_ok    = (cnt_q < CNT_W'(MAX_VOICES)) &&
	                     (eff_len(len_q[item.sound_id]) != '0);
	assign keep        = (vt_rd.pos < eff_len(len_q[vt_rd.sound]));
	assign last_sample = (sif_q == OFF_W'(FRAG_SIZE - 1));
	assign mix_go      = (state_q == S_MIX) && (rd_q < cnt_q);

	// Clamp the signed voice sum to an unsigned output sample
	function automatic logic [7:0] clamp_mix(input logic signed [ACC_W-1:0] s);
		logic [ACC_W-1:0] biased;
		biased = ACC_W'(s + ACC_W'(256));
		if (s > $signed(ACC_W'(255)))
			return 8'd255;
		if (s < -$signed(ACC_W'(256)))
			return 8'd0;
		return biased[8:1];
	endfunction

	// Length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOUND_COUNT; i++)
				len_q[i] <= '0;
		end else if (cfg_we) begin
			len_q[cfg_addr] <= cfg_data;
		end
	end

	// Voice table write: append on start, copy on compaction, advance on mix
	always_comb begin
		vt_wr = '0;
		if (tick_acc && frag_first && item.request == REQ_START && start_ok) begin
			vt_wr.en         = 1'b1;
			vt_wr.idx        = cnt_q[VIDX_W-1:0];
			vt_wr.data.sound = item.sound_id;
			vt_wr.data.pos   = '0;
		end else if (state_q == S_SCAN && rd_q < cnt_q && keep) begin
			vt_wr.en   = 1'b1;
			vt_wr.idx  = wr_q[VIDX_W-1:0];
			vt_wr.data = vt_rd;
		end else if (mix_go && last_sample) begin
			vt_wr.en         = 1'b1;
			vt_wr.idx        = rd_q[VIDX_W-1:0];
			vt_wr.data.sound = vt_rd.sound;
			vt_wr.data.pos   = vt_rd.pos + POS_W'(1);
		end
	end

	mvsm_voice_table u_voices (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (vt_wr),
		.rd_idx  (rd_q[VIDX_W-1:0]),
		.rd_data (vt_rd)
	);

	// Sample memory: flip the top bit on load so it reads back signed
	assign ram_waddr = ADDR_W'({item.sound_id, item.byte_addr});
	assign ram_raddr = {vt_rd.sound, vt_rd.pos[FRAG_W-1:0], sif_q};

	mvsm_sample_ram u_ram (
		.clk      (clk),
		.we       (accept && item.cmd == CMD_LOAD),
		.waddr    (ram_waddr),
		.wdata    (item.raw_byte ^ 8'h80),
		.re       (mix_go),
		.raddr    (ram_raddr),
		.rdata_s1 (rdata_s1)
	);

	// Read-data qualifiers, aligned with the registered memory output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			zero_s1 <= 1'b0;
		end else begin
			vld_s1  <= mix_go;
			zero_s1 <= (vt_rd.pos >= POS_W'(MAX_FRAGS));
		end
	end

	// Sequencer: compaction pass, per-voice accumulation, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			sif_q        <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			fstart_q     <= 1'b0;
			status_q     <= STAT_OK;
			acc_q        <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= (state_q == S_FIN);
			// clear on a new tick, else add the voice sample just read
			if (tick_acc)
				acc_q <= '0;
			else if (vld_s1 && !zero_s1)
				acc_q <= acc_q + ACC_W'($signed(rdata_s1));
			case (state_q)
				S_IDLE: begin
					if (tick_acc) begin
						fstart_q <= frag_first;
						wr_q     <= '0;
						if (frag_first) begin
							state_q  <= S_SCAN;
							status_q <= (item.request == REQ_START && !start_ok) ?
							            STAT_REFUSED : STAT_OK;
							// drop the first voice by skipping it in the pass
							rd_q     <= (item.request == REQ_STOP && cnt_q != '0) ?
							            CNT_W'(1) : '0;
							if (item.request == REQ_START && start_ok)
								cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							state_q  <= S_MIX;
							rd_q     <= '0;
							status_q <= (item.request == REQ_START ||
							             item.request == REQ_STOP) ? STAT_IGNORED : STAT_OK;
						end
					end
				end
				S_SCAN: begin
					if (rd_q < cnt_q) begin
						rd_q <= rd_q + CNT_W'(1);
						if (keep)
							wr_q <= wr_q + CNT_W'(1);
					end else begin
						cnt_q   <= wr_q;
						rd_q    <= '0;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (mix_go)
						rd_q <= rd_q + CNT_W'(1);
					else
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					result.mixed_sample   <= clamp_mix(acc_q);
					result.request_status <= status_q;
					result.fragment_start <= fstart_q;
					result.voices_active  <= 5'(cnt_q);
					if (last_sample)
						sif_q <= '0;
					else
						sif_q <= sif_q + OFF_W'(1);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: test/mvsm_checker.sv
// ----------------------------------------------------------------------------
// mvsm_checker
// Monitor, predictor and scoreboard for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
// Watches the command, result and length-register ports. Every accepted load
// updates a private copy of the sample memory. Every accepted tick runs the
// mixer prediction on a private copy of the voice table and queues the
// predicted result. Each result strobe is checked field by field against the
// oldest queued prediction. Mismatch count and queue depth go to the top.
// ----------------------------------------------------------------------------
module mvsm_checker
	import mvsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  item_t            item,
	input  logic             result_valid,
	input  result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_addr,
	input  logic [LEN_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               results_seen,
	output int               peak_voices,
	output int               refused_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         SOUND_BYTES = MAX_FRAGS * FRAG_SIZE;
	localparam int         MEM_BYTES   = SOUND_COUNT * SOUND_BYTES;
	localparam logic [7:0] SIGN_FLIP   = 8'h80;
	localparam logic [7:0] SILENCE     = 8'd128;
	localparam logic [7:0] LEVEL_TOP   = 8'd255;
	localparam logic [7:0] LEVEL_FLOOR = 8'd0;
	localparam int         CLIP_HI     = 255;
	localparam int         CLIP_LO     = -256;
	localparam int         PRINT_CAP   = 100;

	// Private copy of the block state
	logic [7:0]       pcm_mem [MEM_BYTES];
	logic [LEN_W-1:0] len_reg [SOUND_COUNT];
	logic [SND_W-1:0] v_sound [MAX_VOICES];
	logic [POS_W-1:0] v_pos [MAX_VOICES];
	int               n_voices;
	int               frag_off;
	result_t          want_q [$];

	// Length in fragments, clipped to the sound memory size
	function automatic int capped_len(input logic [SND_W-1:0] s);
		if (int'(len_reg[s]) > MAX_FRAGS)
			return MAX_FRAGS;
		return int'(len_reg[s]);
	endfunction

	// Remove one voice and close the gap in the table
	function automatic void drop_voice(input int idx);
		for (int j = idx; j + 1 < n_voices; j++) begin
			v_sound[j] = v_sound[j + 1];
			v_pos[j]   = v_pos[j + 1];
		end
		if (n_voices > 0)
			n_voices--;
	endfunction

	// Predict one output sample and advance the voice table
	function automatic result_t mix_tick(input item_t it);
		result_t    r;
		int         acc;
		int         k;
		int         a;
		logic       fs;
		logic [1:0] st;
		fs  = (frag_off == 0);
		st  = STAT_OK;
		acc = 0;
		// apply the request and retire finished voices on a fragment start
		if (fs) begin
			if (it.request == REQ_START) begin
				if (n_voices < MAX_VOICES && capped_len(it.sound_id) != 0) begin
					v_sound[n_voices] = it.sound_id;
					v_pos[n_voices]   = '0;
					n_voices++;
				end else begin
					st = STAT_REFUSED;
				end
			end else if (it.request == REQ_STOP) begin
				if (n_voices > 0)
					drop_voice(0);
			end
			k = 0;
			while (k < n_voices) begin
				if (int'(v_pos[k]) >= capped_len(v_sound[k]))
					drop_voice(k);
				else
					k++;
			end
		end else if (it.request == REQ_START || it.request == REQ_STOP) begin
			st = STAT_IGNORED;
		end
		// sum the signed samples of all voices
		for (k = 0; k < n_voices; k++) begin
			a = int'(v_sound[k]) * SOUND_BYTES + int'(v_pos[k]) * FRAG_SIZE + frag_off;
			acc += int'($signed(pcm_mem[a]));
		end
		// saturate into the unsigned output range
		if (n_voices == 0)
			r.mixed_sample = SILENCE;
		else if (acc > CLIP_HI)
			r.mixed_sample = LEVEL_TOP;
		else if (acc < CLIP_LO)
			r.mixed_sample = LEVEL_FLOOR;
		else
			r.mixed_sample = 8'((acc - CLIP_LO) / 2);
		r.request_status = st;
		r.fragment_start = fs;
		r.voices_active  = 5'(n_voices);
		// advance every voice after the last sample of a fragment
		frag_off++;
		if (frag_off == FRAG_SIZE) begin
			frag_off = 0;
			for (k = 0; k < n_voices; k++)
				v_pos[k]++;
		end
		return r;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want_v);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: mismatch on %s, got %0d, predicted %0d (result %0d)",
				$time, what, got, want_v, results_seen);
		fail_count++;
	endtask

	// Check results, track register writes and predict accepted transactions
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		result_t want;
		if (!arst_n) begin
			foreach (len_reg[i])
				len_reg[i] = '0;
			foreach (v_sound[i]) begin
				v_sound[i] = '0;
				v_pos[i]   = '0;
			end
			n_voices     = 0;
			frag_off     = 0;
			want_q.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			peak_voices  = 0;
			refused_seen = 0;
		end else begin
			// compare a result with the oldest prediction
			if (result_valid) begin
				results_seen++;
				if (want_q.size() == 0) begin
					report_mismatch("result with no pending tick", 16'(result), '0);
				end else begin
					want = want_q.pop_front();
					if (result.mixed_sample !== want.mixed_sample)
						report_mismatch("mixed_sample", 16'(result.mixed_sample),
							16'(want.mixed_sample));
					if (result.request_status !== want.request_status)
						report_mismatch("request_status", 16'(result.request_status),
							16'(want.request_status));
					if (result.fragment_start !== want.fragment_start)
						report_mismatch("fragment_start", 16'(result.fragment_start),
							16'(want.fragment_start));
					if (result.voices_active !== want.voices_active)
						report_mismatch("voices_active", 16'(result.voices_active),
							16'(want.voices_active));
				end
			end
			// hold the length registers
			if (cfg_we)
				len_reg[cfg_addr] = cfg_data;
			// every sound id and byte offset is in range, so a load always lands
			if (start && !busy) begin
				if (item.cmd == CMD_LOAD) begin
					pcm_mem[int'(item.sound_id) * SOUND_BYTES + int'(item.byte_addr)] =
						item.raw_byte ^ SIGN_FLIP;
				end else begin
					want = mix_tick(item);
					want_q.push_back(want);
					if (want.request_status == STAT_REFUSED)
						refused_seen++;
					if (int'(want.voices_active) > peak_voices)
						peak_voices = int'(want.voices_active);
				end
			end
			pending = want_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
// Opens a fragment with a start of an unavailable sound, loads a few bytes
// with stray requests, then preloads the head of the first fragment of one
// sound. The rest of that fragment runs silent with stray requests, a full
// drain and a length rewrite in the middle, and a stretch without idle gaps.
// The next fragment start launches the preloaded sound and plays only its
// loaded head, so no voice ever reads an unwritten byte. Lengths are written
// only with the block idle. The checker beside the block predicts and
// compares; this module reports.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mvsm_pkg::*;

	localparam logic [1:0]       REQ_UNUSED  = 2'd3;   // request code with no meaning
	localparam int               IDLE_PCT    = 35;
	localparam int               STALL_LIMIT = 2000;
	localparam int               HEAD_SPAN   = 64;     // offsets preloaded and played
	localparam int               LOUD_SPAN   = 8;      // offsets at full scale
	localparam int               QUIET_SPAN  = 16;     // offsets from LOUD_SPAN below this at bottom scale
	localparam int               DRAIN_AT    = 100;    // fragment offset of the drain
	localparam int               BURST_LO    = 200;    // no idle gaps from here ...
	localparam int               BURST_HI    = 400;    // ... up to here
	localparam logic [SND_W-1:0] PLAY_SOUND  = 3'd4;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	item_t            item = '0;
	logic             result_valid;
	result_t          result;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_addr = '0;
	logic [LEN_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int results_seen;
	int peak_voices;
	int refused_seen;

	bit               idle_on = 1'b0;
	int               frag_pos = 0;
	int               n_loads = 0;
	int               n_ticks = 0;
	int               n_frag_starts = 0;
	int               idle_cycles = 0;
	logic [LEN_W-1:0] len_plan [SOUND_COUNT];

	multi_voice_sample_mixer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	mvsm_checker mix_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.peak_voices  (peak_voices),
		.refused_seen (refused_seen)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d results outstanding", idle_cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic item_t mk_item(input logic c, input logic [1:0] rq,
			input logic [2:0] sid, input logic [13:0] addr, input logic [7:0] raw);
		item_t it;
		it.cmd       = c;
		it.request   = rq;
		it.sound_id  = sid;
		it.byte_addr = addr;
		it.raw_byte  = raw;
		return it;
	endfunction

	// Offer one transaction and hold it until accepted; returns on a falling edge
	task automatic send_item(input item_t it);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (it.cmd == CMD_LOAD) begin
			n_loads++;
		end else begin
			if (frag_pos == 0)
				n_frag_starts++;
			n_ticks++;
			frag_pos = (frag_pos + 1) % FRAG_SIZE;
		end
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_lengths();
		for (int r = 0; r < SOUND_COUNT; r++) begin
			cfg_we   <= 1'b1;
			cfg_addr <= CFG_W'(r);
			cfg_data <= len_plan[r];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] raw;
		int         roll;
		logic [1:0] rq;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// unavailable, short, full and oversized lengths
		len_plan = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd63, 6'd3, 6'd1, 6'd0};
		write_lengths();

		// first fragment start: a start of an unavailable sound is refused
		idle_on = 1'b1;
		send_item(mk_item(CMD_TICK, REQ_START, 3'd0, 14'h3FFF, 8'hFF));

		// loads carrying requests, field extremes
		send_item(mk_item(CMD_LOAD, REQ_UNUSED, 3'd7, 14'h3FFF, 8'h00));
		send_item(mk_item(CMD_LOAD, REQ_START, 3'd0, 14'h0000, 8'hFF));
		send_item(mk_item(CMD_LOAD, REQ_STOP, 3'd2, 14'h2AAA, 8'h55));
		send_item(mk_item(CMD_LOAD, REQ_NONE, 3'd6, 14'h1555, 8'hAA));

		// preload the head of the first fragment of the sound played next
		for (int off = 0; off < HEAD_SPAN; off++) begin
			if (off < LOUD_SPAN)
				raw = 8'hFF;
			else if (off < QUIET_SPAN)
				raw = 8'h00;
			else
				raw = 8'($urandom);
			send_item(mk_item(CMD_LOAD, 2'($urandom), PLAY_SOUND, 14'(off), raw));
		end

		// silent rest of the fragment, with stray requests mid-fragment
		while (frag_pos != 0) begin
			if (frag_pos == DRAIN_AT) begin
				drain_results();
				len_plan[PLAY_SOUND] = 6'd33;
				write_lengths();
			end
			idle_on = !(frag_pos >= BURST_LO && frag_pos < BURST_HI);
			rq = REQ_NONE;
			if ($urandom_range(99) < 5) begin
				roll = $urandom_range(2);
				rq = (roll == 0) ? REQ_START : (roll == 1) ? REQ_STOP : REQ_UNUSED;
			end
			send_item(mk_item(CMD_TICK, rq, 3'($urandom), 14'($urandom), 8'($urandom)));
		end
		idle_on = 1'b1;

		// next fragment start: launch the preloaded sound and play its head
		send_item(mk_item(CMD_TICK, REQ_START, PLAY_SOUND, 14'h0000, 8'h00));
		while (frag_pos < HEAD_SPAN)
			send_item(mk_item(CMD_TICK, REQ_NONE, 3'($urandom), 14'($urandom),
				8'($urandom)));

		// drain
		drain_results();
		repeat (4) @(negedge clk);

		$display("covered %0d loads and %0d ticks over %0d fragment starts, %0d results checked",
			n_loads, n_ticks, n_frag_starts, results_seen);
		$display("voice table peaked at %0d voices, %0d start requests refused",
			peak_voices, refused_seen);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/mvsm_pkg.sv
rtl/mvsm_sample_ram.sv
rtl/mvsm_voice_table.sv
rtl/multi_voice_sample_mixer.sv
test/mvsm_checker.sv
test/tb_top.sv
